// ----- src/vlc_pkg.sv -----
// Package for the prefix-code tree decoder: sizes, node layout, codes.
// No dependencies; used by vlc_code_tree_decoder.
package vlc_pkg;

  localparam int NODES   = 512;
  localparam int SYMBOLS = 256;
  localparam int PTR_W   = $clog2(NODES);
  localparam int CNT_W   = $clog2(NODES + 1);
  localparam int SYM_W   = 8;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_PENDING = 3'd0,
    ST_SYMBOL  = 3'd1,
    ST_NOMATCH = 3'd2,
    ST_STORED  = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  // One child link plus the symbol index held at that child.
  typedef struct packed {
    logic [PTR_W-1:0] ptr;
    logic             has_index;
    logic [SYM_W-1:0] index;
  } slot_t;

  typedef struct packed {
    slot_t right;
    slot_t left;
  } node_t;

endpackage

// ----- src/vlc_code_tree_decoder.sv -----
// Prefix-code tree decoder: load codewords bit by bit, decode a bit stream.
// Node store is one single-port synchronous RAM. Depends on vlc_pkg.
//
//  channel | dir | handshake         | payload
//  s_axis  | in  | tvalid/tready     | tuser=opcode, tlast=is_last, tdata=code_bit,symbol_in
//  m_axis  | out | tvalid/tready     | tdata=status,symbol_out
//
// Each item is handled in two steps: a node read at the cursor on the accept cycle,
// then, in S_EXEC, the decision and write-back of that node. The registered RAM read sets this.
// After reset a clearing pass writes all NODES entries with s_axis_tready low.
// A stalled output holds the item in S_EXEC; no new item is taken until it is done.
module vlc_code_tree_decoder
  import vlc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] code_bit, [8:1] symbol_in
  input  logic                  s_axis_tuser,   // [0] opcode
  input  logic                  s_axis_tlast,   // is_last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [2:0] status, [10:3] symbol_out
);

  node_t            mem [NODES];
  node_t            rd_q;

  state_e           state_q, state_d;
  logic [PTR_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0] nodes_used_q, nodes_used_d;
  logic [PTR_W-1:0] load_cursor_q, load_cursor_d;
  logic [PTR_W-1:0] decode_cursor_q, decode_cursor_d;

  op_e              op_q;
  logic             bit_q, last_q;
  logic [SYM_W-1:0] sym_q;
  logic [PTR_W-1:0] addr_q;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [SYM_W-1:0] out_sym_q, out_sym_d;

  logic             in_xfer;
  logic             out_free;
  op_e              in_op;
  logic [PTR_W-1:0] rd_addr;
  logic             rd_en;
  logic             we;
  logic [PTR_W-1:0] waddr;
  node_t            wdata;
  slot_t            slot, slot_new;
  node_t            node_new;
  logic [SYM_W-1:0] sym_mod;

  assign in_op    = op_e'(s_axis_tuser);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign rd_addr  = (in_op == OP_DECODE) ? decode_cursor_q : load_cursor_q;
  assign rd_en    = in_xfer;
  assign sym_mod  = SYM_W'(32'(sym_q) % SYMBOLS);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_sym_q, out_status_q});

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= in_op;
      bit_q  <= s_axis_tdata[0];
      last_q <= s_axis_tlast;
      sym_q  <= s_axis_tdata[SYM_W:1];
      addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_sym_q    <= out_sym_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLEAR;
      clr_q           <= '0;
      nodes_used_q    <= CNT_W'(1);
      load_cursor_q   <= '0;
      decode_cursor_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      clr_q           <= clr_d;
      nodes_used_q    <= nodes_used_d;
      load_cursor_q   <= load_cursor_d;
      decode_cursor_q <= decode_cursor_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    clr_d           = clr_q;
    nodes_used_d    = nodes_used_q;
    load_cursor_d   = load_cursor_q;
    decode_cursor_d = decode_cursor_q;
    out_valid_d     = out_valid_q && !m_axis_tready;
    out_status_d    = out_status_q;
    out_sym_d       = out_sym_q;
    we              = 1'b0;
    waddr           = addr_q;
    wdata           = '0;
    slot            = bit_q ? rd_q.right : rd_q.left;
    slot_new        = slot;
    node_new        = rd_q;

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + PTR_W'(1);
        if (clr_q == PTR_W'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d      = S_IDLE;
          out_valid_d  = 1'b1;
          out_sym_d    = '0;
          out_status_d = ST_PENDING;
          if (op_q == OP_LOAD) begin
            if (slot.ptr == '0 && nodes_used_q == CNT_W'(NODES)) begin
              load_cursor_d = '0;
              out_status_d  = ST_FULL;
            end else begin
              if (slot.ptr == '0) begin
                slot_new.ptr = nodes_used_q[PTR_W-1:0];
                nodes_used_d = nodes_used_q + CNT_W'(1);
              end
              if (last_q) begin
                slot_new.has_index = 1'b1;
                slot_new.index     = sym_mod;
                load_cursor_d      = '0;
                out_status_d       = ST_STORED;
              end else begin
                load_cursor_d = slot_new.ptr;
              end
              if (bit_q) begin
                node_new.right = slot_new;
              end else begin
                node_new.left = slot_new;
              end
              we    = 1'b1;
              wdata = node_new;
            end
          end else begin
            if (slot.ptr == '0) begin
              decode_cursor_d = '0;
              out_status_d    = ST_NOMATCH;
            end else if (slot.has_index) begin
              decode_cursor_d = '0;
              out_status_d    = ST_SYMBOL;
              out_sym_d       = slot.index;
            end else begin
              decode_cursor_d = slot.ptr;
            end
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

`ifndef SYNTH
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_used_q != '0 && nodes_used_q <= CNT_W'(NODES))
    else $error("node count out of range");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_used_q == $past(nodes_used_q) || nodes_used_q == $past(nodes_used_q) + CNT_W'(1))
    else $error("node count jumped");

  a_cursors_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(load_cursor_q) < nodes_used_q && CNT_W'(decode_cursor_q) < nodes_used_q)
    else $error("cursor points past allocated nodes");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_EXEC))
    else $error("result without an item in progress");
`endif

endmodule
